// File: sv/ght_pkg.sv
// Package with the shared types and constants of the generational handle table.
`timescale 1ns / 1ps
`default_nettype none
package ght_pkg;

  localparam int MAX_PARTITIONS_DEFAULT = 8;
  localparam int CAPACITY_DEFAULT       = 256;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key;
    logic [63:0] gen_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] key_out;
    logic [63:0] gen_out;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [63:0] gen;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: sv/ght_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/ght_mod.sv
// Bit-serial remainder unit: 64-bit key modulo a small divisor.
`timescale 1ns / 1ps
`default_nettype none
module ght_mod #(
  parameter int PW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [63:0]   dividend,
  input  wire logic [PW-1:0] divisor,
  output logic               done,
  output logic      [PW-1:0] rem
);

  logic [63:0]   shreg;
  logic [PW-1:0] dvs;
  logic [5:0]    cnt;
  logic          running;
  logic [PW-1:0] trial;

  // Shift the next dividend bit in and subtract the divisor once if it fits.
  assign trial = {rem[PW-2:0], shreg[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (running) begin
      shreg <= {shreg[62:0], 1'b0};
      rem   <= (trial >= dvs) ? trial - dvs : trial;
    end
  end

endmodule
`default_nettype wire

// File: sv/generational_handle_table_unit.sv
// Top level of the generational handle table: control, counters and entry store.
`timescale 1ns / 1ps
`default_nettype none
// Usage.
// Commands enter on cmd and are taken at a rising edge where start is high and
// busy is low. Each command gives exactly one result, shown on result for one
// cycle with result_valid high; the receiver takes it there and cannot stall.
// The partition count is written through cfg_valid/cfg_ready/cfg_data; the
// port is always ready and must only be used while the block is idle.
// Operation. A lookup or delete walks the entry store one entry a cycle through
// the single read port of the entry RAM, from the first entry until a hit or
// the last entry, and then gives its result. An insert first runs the
// bit-serial partition remainder and then walks the store to check for a
// duplicate and find the lowest free slot; a duplicate ends the walk early.
// Unused opcodes go straight to the result.
// Reset. After rst the block runs a clearing pass over the entry RAM, one
// entry a cycle, with busy held high; the partition counters return to zero
// and the partition count to one.
// The entry RAM is only written in the clearing pass and in the final cycle
// of a command, so reads and writes of one entry never overlap.
module generational_handle_table_unit #(
  parameter int MAX_PARTITIONS = ght_pkg::MAX_PARTITIONS_DEFAULT,
  parameter int CAPACITY       = ght_pkg::CAPACITY_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire ght_pkg::cmd_t   cmd,
  output logic                 result_valid,
  output ght_pkg::result_t     result,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [3:0]      cfg_data
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int PW  = $clog2(MAX_PARTITIONS) + 2;
  localparam int PIW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CW  = (PW > 4) ? PW : 4;
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  ght_pkg::state_t state, state_next;

  // Configuration register; the port never needs to push back.
  logic [3:0]    num_partitions;
  logic [CW-1:0] np_wide;
  logic [PW-1:0] eff_parts;

  assign cfg_ready = 1'b1;
  assign np_wide   = CW'(num_partitions);

  always_comb begin
    if (np_wide == '0) begin
      eff_parts = PW'(1);
    end else if (np_wide > CW'(MAX_PARTITIONS)) begin
      eff_parts = PW'(MAX_PARTITIONS);
    end else begin
      eff_parts = PW'(np_wide);
    end
  end

  // The command being worked on is held for the whole walk.
  ght_pkg::cmd_t op;
  logic          accept;

  assign busy   = (state != ght_pkg::S_IDLE);
  assign accept = start && !busy;

  // Partition remainder unit.
  logic          mod_start;
  logic          mod_done;
  logic [PW-1:0] mod_rem;
  logic [PIW-1:0] part;

  ght_mod #(.PW(PW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (cmd.key),
    .divisor  (eff_parts),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Entry store.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  ght_pkg::entry_t      ram_wdata;
  ght_pkg::entry_t      ram_rdata;
  logic [AW-1:0]        addr;

  ght_ram #(.WIDTH($bits(ght_pkg::entry_t)), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // Walk state: addr issues reads, pend marks that ram_rdata belongs to chk.
  logic          issuing;
  logic          pend;
  logic [AW-1:0] chk;
  logic          hit;
  logic [AW-1:0] hit_slot;
  logic [63:0]   hit_gen;
  logic          free_found;
  logic [AW-1:0] free_slot;
  logic          match;

  assign match = pend && ram_rdata.valid && (ram_rdata.key == op.key);

  logic [63:0] pc [MAX_PARTITIONS];
  logic [63:0] gen_new;

  assign gen_new = pc[part] + 64'd1;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ght_pkg::S_CLEAR: begin
        if (addr == LAST) begin
          state_next = ght_pkg::S_IDLE;
        end
      end
      ght_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cmd.opcode)
            ght_pkg::OP_INSERT: state_next = ght_pkg::S_MOD;
            ght_pkg::OP_LOOKUP,
            ght_pkg::OP_DELETE: state_next = ght_pkg::S_SCAN;
            default:            state_next = ght_pkg::S_DONE;
          endcase
        end
      end
      ght_pkg::S_MOD: begin
        if (mod_done) begin
          state_next = ght_pkg::S_SCAN;
        end
      end
      ght_pkg::S_SCAN: begin
        if (match || (pend && chk == LAST)) begin
          state_next = ght_pkg::S_DONE;
        end
      end
      ght_pkg::S_DONE: begin
        state_next = ght_pkg::S_IDLE;
      end
      default: state_next = ght_pkg::S_IDLE;
    endcase
  end

  // Output and RAM write logic.
  ght_pkg::result_t res_next;
  logic             pc_bump;

  always_comb begin
    mod_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = '0;
    res_next  = '{status: ght_pkg::ST_MISS, key_out: 64'd0, gen_out: 64'd0};
    pc_bump   = 1'b0;
    unique case (state)
      ght_pkg::S_CLEAR: begin
        ram_we = 1'b1;
      end
      ght_pkg::S_IDLE: begin
        mod_start = accept && (cmd.opcode == ght_pkg::OP_INSERT);
      end
      ght_pkg::S_DONE: begin
        if (op.opcode == ght_pkg::OP_INSERT) begin
          pc_bump = 1'b1;
          if (hit) begin
            res_next.status = ght_pkg::ST_DUP;
          end else if (free_found) begin
            ram_we          = 1'b1;
            ram_waddr       = free_slot;
            ram_wdata       = '{valid: 1'b1, key: op.key, gen: gen_new};
            res_next        = '{status: ght_pkg::ST_OK, key_out: op.key, gen_out: gen_new};
          end else begin
            res_next.status = ght_pkg::ST_FULL;
          end
        end else if ((op.opcode == ght_pkg::OP_LOOKUP || op.opcode == ght_pkg::OP_DELETE)
                     && hit && hit_gen == op.gen_in) begin
          res_next = '{status: ght_pkg::ST_OK, key_out: op.key, gen_out: op.gen_in};
          if (op.opcode == ght_pkg::OP_DELETE) begin
            ram_we    = 1'b1;
            ram_waddr = hit_slot;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ght_pkg::S_CLEAR;
      num_partitions <= 4'd1;
      result_valid   <= 1'b0;
      addr           <= '0;
      issuing        <= 1'b0;
      pend           <= 1'b0;
      for (int i = 0; i < MAX_PARTITIONS; i++) begin
        pc[i] <= 64'd0;
      end
    end else begin
      state        <= state_next;
      result_valid <= (state == ght_pkg::S_DONE);
      if (cfg_valid && cfg_ready) begin
        num_partitions <= cfg_data;
      end
      if (pc_bump) begin
        pc[part] <= gen_new;
      end
      if (state == ght_pkg::S_CLEAR) begin
        addr <= addr + AW'(1);
      end else if (state_next == ght_pkg::S_SCAN && state != ght_pkg::S_SCAN) begin
        addr    <= '0;
        issuing <= 1'b1;
        pend    <= 1'b0;
      end else if (state == ght_pkg::S_SCAN) begin
        pend <= issuing && (state_next == ght_pkg::S_SCAN);
        if (issuing) begin
          addr <= addr + AW'(1);
          if (addr == LAST) begin
            issuing <= 1'b0;
          end
        end
      end else begin
        issuing <= 1'b0;
        pend    <= 1'b0;
      end
    end
  end

  // Payload registers of the walk and the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= cmd;
      part       <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end
    if (mod_done) begin
      part <= mod_rem[PIW-1:0];
    end
    if (state == ght_pkg::S_SCAN) begin
      chk <= addr;
      if (match) begin
        hit      <= 1'b1;
        hit_slot <= chk;
        hit_gen  <= ram_rdata.gen;
      end
      if (pend && !ram_rdata.valid && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= chk;
      end
    end
    if (state == ght_pkg::S_DONE) begin
      result <= res_next;
    end
  end

`ifndef ASSERT_OFF
  // A result only follows the final cycle of a command.
  a_result_after_done: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == ght_pkg::S_DONE)
    else $error("result without a finished command");

  // The entry RAM is never written while the partition remainder runs or the store is being walked.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ght_pkg::S_SCAN || state == ght_pkg::S_MOD) |-> !ram_we)
    else $error("entry RAM written during a walk");

  // A successful result carries the key of the command that produced it.
  a_ok_key: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ght_pkg::ST_OK) |-> result.key_out == op.key)
    else $error("ok result with the wrong key");

  // No command is taken during the clearing pass.
  a_busy_clear: assert property (@(posedge clk) disable iff (rst)
    state == ght_pkg::S_CLEAR |-> busy)
    else $error("not busy during clearing pass");
`endif

endmodule
`default_nettype wire

// File: bench/ght_checker.sv
// Checker for the generational handle table: predicts each result and compares.
`timescale 1ns / 1ps
module ght_checker
  import ght_pkg::*;
#(
  parameter int MAX_PARTITIONS = 8,
  parameter int CAPACITY       = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  cmd_t       cmd,
  input  logic       result_valid,
  input  result_t    result,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [3:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         results_seen
);

  logic        slot_used [CAPACITY];
  logic [63:0] slot_key  [CAPACITY];
  logic [63:0] slot_gen  [CAPACITY];
  logic [63:0] part_gen  [MAX_PARTITIONS];
  logic [3:0]  part_count;
  result_t     expected_results [$];

  assign pending = expected_results.size();

  function automatic result_t predict_handle_op(cmd_t c);
    result_t r;
    int      n;
    int      p;
    int      hit;
    int      free_slot;
    r = '{status: ST_MISS, key_out: '0, gen_out: '0};
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_used[i] && slot_key[i] == c.key && hit < 0) hit = i;
      if (!slot_used[i] && free_slot < 0) free_slot = i;
    end
    if (c.opcode == OP_INSERT) begin
      n = (part_count == 0) ? 1 : (part_count > MAX_PARTITIONS) ? MAX_PARTITIONS : part_count;
      p = int'(c.key % 64'(n));
      part_gen[p] = part_gen[p] + 64'd1;
      if (hit >= 0) r.status = ST_DUP;
      else if (free_slot < 0) r.status = ST_FULL;
      else begin
        slot_used[free_slot] = 1'b1;
        slot_key[free_slot] = c.key;
        slot_gen[free_slot] = part_gen[p];
        r = '{status: ST_OK, key_out: c.key, gen_out: part_gen[p]};
      end
    end else if (c.opcode == OP_LOOKUP || c.opcode == OP_DELETE) begin
      if (hit >= 0 && slot_gen[hit] == c.gen_in) begin
        r = '{status: ST_OK, key_out: c.key, gen_out: c.gen_in};
        if (c.opcode == OP_DELETE) slot_used[hit] = 1'b0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) slot_used[i] <= 1'b0;
      for (int i = 0; i < MAX_PARTITIONS; i++) part_gen[i] <= '0;
      part_count <= 4'd1;
      expected_results.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) part_count <= cfg_data;
      if (result_valid) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.status !== result.status || want.key_out !== result.key_out
              || want.gen_out !== result.gen_out) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, result);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_results.push_back(predict_handle_op(cmd));
    end
  end

endmodule

// File: bench/tb_generational_handle_table_unit.sv
// Testbench top: drives commands and partition counts, and gives the verdict.
`timescale 1ns / 1ps
module tb_generational_handle_table_unit;
  import ght_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  cmd_t       cmd = '0;
  logic       result_valid;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = 4'd0;
  int         fail_count;
  int         pending;
  int         results_seen;
  int         cycles = 0;

  // Keys live in a small pool so that duplicates and hits happen.
  logic [63:0] key_pool [48];
  logic [63:0] gen_seen [48];

  always #10 clk = ~clk;

  generational_handle_table_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ght_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  // A watchdog sized for about 2000 inserts, with long idle gaps, taken several
  // times over.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    repeat (n) @(negedge clk);
  endtask

  // Present one transaction and hold it until the block takes it.
  task automatic issue_command(logic [1:0] op, logic [63:0] key, logic [63:0] gen);
    @(negedge clk);
    cmd <= '{opcode: op, key: key, gen_in: gen};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Waits for every outstanding result, then for the block to go idle, so a
  // register write never overlaps a command.
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_partitions(logic [3:0] value);
    drain();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [63:0] k;
    int          idx;
    int          op_pick;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 48; i++) begin
      key_pool[i] = {$urandom(), $urandom()};
      gen_seen[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;

    // Directed part: extremes of key and generation, a duplicate insert,
    // a miss on wrong generation, a delete and a re-lookup, the unused opcode.
    issue_command(OP_INSERT, 64'd0, '1);
    issue_command(OP_INSERT, '1, 64'd0);
    issue_command(OP_INSERT, '1, 64'd5);
    issue_command(OP_LOOKUP, 64'd0, 64'd1);
    issue_command(OP_LOOKUP, '1, 64'd2);
    issue_command(OP_LOOKUP, '1, 64'd9);
    issue_command(OP_DELETE, 64'd0, 64'd7);
    issue_command(OP_DELETE, 64'd0, 64'd1);
    issue_command(OP_LOOKUP, 64'd0, 64'd1);
    issue_command(OP_UNUSED, '1, '1);
    issue_command(OP_LOOKUP, 64'h5555_5555_5555_5555, '0);

    // Out-of-range partition counts: zero acts as one, above the maximum clamps.
    write_partitions(4'd0);
    issue_command(OP_INSERT, 64'd7, '0);
    write_partitions(4'd15);
    issue_command(OP_INSERT, 64'd15, '0);
    issue_command(OP_LOOKUP, '1, 64'd2);
    write_partitions(4'd8);
    issue_command(OP_INSERT, 64'd23, '0);

    // Fill the store past the point where it reports full, then delete the fill
    // keys again with matching generations computed from the partition counter.
    write_partitions(4'd1);
    for (int i = 0; i < 262; i++)
      issue_command(OP_INSERT, 64'h1000_0000 + 64'(i), '0);
    drain();
    // Partition 0 stood at 4 before the fill, so fill key i received
    // generation i + 5; the keys past the full point miss.
    for (int i = 0; i < 262; i++)
      issue_command(OP_DELETE, 64'h1000_0000 + 64'(i), 64'(i + 5));
    drain();

    // Random part over several partition settings, the extremes among them.
    for (int phase = 0; phase < 8; phase++) begin
      write_partitions(phase == 0 ? 4'd1 : phase == 7 ? 4'd8 : 4'($urandom_range(0, 15)));
      for (int n = 0; n < 176; n++) begin
        idx = $urandom_range(0, 47);
        k = key_pool[idx];
        op_pick = $urandom_range(0, 19);
        if ($urandom_range(0, 15) == 0) k = {$urandom(), $urandom()};
        if (op_pick < 7)
          issue_command(OP_INSERT, k, {$urandom(), $urandom()});
        else if (op_pick < 19) begin
          // Most lookups and deletes use a generation near the live counters.
          issue_command(op_pick < 13 ? OP_LOOKUP : OP_DELETE, k,
                        ($urandom_range(0, 3) == 0) ? {$urandom(), $urandom()}
                                                    : 64'($urandom_range(0, 700)));
        end else
          issue_command(OP_UNUSED, k, {$urandom(), $urandom()});
        if ($urandom_range(0, 2) == 0) idle_gap();
      end
      // After the fourth phase the sender holds off until every expected result has arrived.
      if (phase == 3) drain();
    end

    drain();
    repeat (CAPACITY_DEFAULT + 80) @(negedge clk);
    $display("Covered directed extremes, a full store, unused opcode and %0d results",
             results_seen);
    $display("over eight partition settings including 0, 1, 8 and 15.");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: generational_handle_table_unit.f
sv/ght_pkg.sv
sv/ght_ram.sv
sv/ght_mod.sv
sv/generational_handle_table_unit.sv
bench/ght_checker.sv
bench/tb_generational_handle_table_unit.sv
